>>> hdl/pthc_pkg.sv
// Shared types, constants and fixed-point helpers for the sensor compensation block.
package pthc_pkg;

   localparam int TEMP_FRAC_BITS_DEF = 24;
   localparam int DIV_W = 32;

   localparam logic [1:0] CSR_TEMP_CAL       = 2'd0;
   localparam logic [1:0] CSR_PRESS_CAL_LOW  = 2'd1;
   localparam logic [1:0] CSR_PRESS_CAL_HIGH = 2'd2;
   localparam logic [1:0] CSR_HUM_CAL        = 2'd3;

   typedef struct packed {
      logic             vld;
      logic [DIV_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             vld;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

   // signed divide by 2^k, rounding toward zero
   function automatic logic signed [31:0] tdiv(input logic signed [31:0] x,
                                               input int unsigned k);
      logic signed [31:0] b;
      b = x[31] ? ((32'sd1 <<< k) - 32'sd1) : 32'sd0;
      return (x + b) >>> k;
   endfunction

   function automatic logic signed [31:0] sx16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

endpackage

>>> hdl/pthc_div.sv
// Pipelined restoring divider, one quotient bit per stage, unsigned 32 by 32.
module pthc_div
   import pthc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic             vld_ff [DIV_W];
   logic [DIV_W-1:0] rem_ff [DIV_W];
   logic [DIV_W-1:0] num_ff [DIV_W];
   logic [DIV_W-1:0] quo_ff [DIV_W];
   logic [DIV_W-1:0] dsr_ff [DIV_W];

   logic [DIV_W-1:0] rem_in [DIV_W];
   logic [DIV_W-1:0] num_in [DIV_W];
   logic [DIV_W-1:0] quo_in [DIV_W];
   logic [DIV_W-1:0] dsr_in [DIV_W];

   logic [DIV_W-1:0] src_rem [DIV_W];
   logic [DIV_W-1:0] src_num [DIV_W];
   logic [DIV_W-1:0] src_quo [DIV_W];
   logic [DIV_W-1:0] src_dsr [DIV_W];
   logic [DIV_W:0]   trial   [DIV_W];
   logic             take    [DIV_W];

   always_comb begin
      src_rem[0] = '0;
      src_num[0] = req.dividend;
      src_quo[0] = '0;
      src_dsr[0] = req.divisor;
      for (int k = 1; k < DIV_W; k++) begin
         src_rem[k] = rem_ff[k-1];
         src_num[k] = num_ff[k-1];
         src_quo[k] = quo_ff[k-1];
         src_dsr[k] = dsr_ff[k-1];
      end
      for (int k = 0; k < DIV_W; k++) begin
         trial[k] = {src_rem[k], src_num[k][DIV_W-1]};
         take[k]  = (trial[k] >= {1'b0, src_dsr[k]});
         rem_in[k] = take[k] ? DIV_W'(trial[k] - {1'b0, src_dsr[k]})
                             : trial[k][DIV_W-1:0];
         num_in[k] = {src_num[k][DIV_W-2:0], 1'b0};
         quo_in[k] = {src_quo[k][DIV_W-2:0], take[k]};
         dsr_in[k] = src_dsr[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_W; k++) vld_ff[k] <= 1'b0;
      end else begin
         vld_ff[0] <= req.vld;
         for (int k = 1; k < DIV_W; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < DIV_W; k++) begin
         rem_ff[k] <= rem_in[k];
         num_ff[k] <= num_in[k];
         quo_ff[k] <= quo_in[k];
         dsr_ff[k] <= dsr_in[k];
      end
   end

   assign rsp.vld      = vld_ff[DIV_W-1];
   assign rsp.quotient = quo_ff[DIV_W-1];

endmodule

>>> hdl/pth_sensor_compensation.sv
// Top level: temperature, pressure and humidity compensation pipeline with APB calibration port.
// Each result reaches rsp_valid through the 32-stage pressure divider plus 16 stages of
//   arithmetic around it.
// Throughput: one request per cycle; busy stays low and results cannot be held off.
// Reset: synchronous, active high; clears all valid bits and the calibration registers.
module pth_sensor_compensation
   import pthc_pkg::*;
#(
   parameter int TEMP_FRAC_BITS = TEMP_FRAC_BITS_DEF
)(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [19:0]        req_raw_temperature,
   input  logic [19:0]        req_raw_pressure,
   input  logic [15:0]        req_raw_humidity,
   output logic               rsp_valid,
   output logic signed [14:0] rsp_temp_centi,
   output logic [16:0]        rsp_pressure_pa,
   output logic [16:0]        rsp_humidity_q10,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [63:0]        pwdata,
   output logic [63:0]        prdata,
   output logic               pready
);

   localparam int F     = TEMP_FRAC_BITS;
   localparam int NUM_W = 59;
   localparam int SHR   = (F < 34) ? 34 - F : 0;
   localparam int SHL   = (F > 34) ? F - 34 : 0;
   localparam int SQ_W  = NUM_W + SHL;
   localparam int CW    = SQ_W + 3;
   localparam logic signed [SQ_W-1:0] CHI  = SQ_W'(435200) << F;
   localparam logic signed [SQ_W-1:0] CLO  = -(SQ_W'(204800) << F);
   localparam logic signed [CW-1:0]   CRND = CW'(1) << (F + 7);

   // pipeline positions of the side results and the output register
   localparam int STG_CENTI = 6;
   localparam int STG_HUM   = 16;
   localparam int STG_OUT   = 48;
   localparam int CENTI_DLY = STG_OUT - STG_CENTI - 1;
   localparam int HUM_DLY   = STG_OUT - STG_HUM - 1;
   localparam int PRE_N     = 11;
   localparam int POST_N    = 5;

   // ---------------- calibration registers ----------------
   logic [63:0] temp_cal_ff, press_cal_low_ff, press_cal_high_ff, hum_cal_ff;
   logic        csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_cal_ff       <= '0;
         press_cal_low_ff  <= '0;
         press_cal_high_ff <= '0;
         hum_cal_ff        <= '0;
      end else if (csr_wr) begin
         case (paddr[4:3])
            CSR_TEMP_CAL:       temp_cal_ff       <= pwdata;
            CSR_PRESS_CAL_LOW:  press_cal_low_ff  <= pwdata;
            CSR_PRESS_CAL_HIGH: press_cal_high_ff <= pwdata;
            CSR_HUM_CAL:        hum_cal_ff        <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[4:3])
         CSR_TEMP_CAL:       prdata = temp_cal_ff;
         CSR_PRESS_CAL_LOW:  prdata = press_cal_low_ff;
         CSR_PRESS_CAL_HIGH: prdata = press_cal_high_ff;
         CSR_HUM_CAL:        prdata = hum_cal_ff;
         default:            prdata = '0;
      endcase
   end

   // Unpack cal words; user must change config only while idle, unchecked; stages read them.
   logic [15:0]        t1_c;
   logic signed [15:0] t2_c, t3_c;
   logic signed [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
   logic signed [31:0] h1, h2, h3, h4, h5, h6;

   assign t1_c = temp_cal_ff[15:0];
   assign t2_c = temp_cal_ff[31:16];
   assign t3_c = temp_cal_ff[47:32];
   assign p9   = sx16(temp_cal_ff[63:48]);
   assign p1   = {16'b0, press_cal_low_ff[15:0]};
   assign p2   = sx16(press_cal_low_ff[31:16]);
   assign p3   = sx16(press_cal_low_ff[47:32]);
   assign p4   = sx16(press_cal_low_ff[63:48]);
   assign p5   = sx16(press_cal_high_ff[15:0]);
   assign p6   = sx16(press_cal_high_ff[31:16]);
   assign p7   = sx16(press_cal_high_ff[47:32]);
   assign p8   = sx16(press_cal_high_ff[63:48]);
   assign h1   = {24'b0, hum_cal_ff[7:0]};
   assign h2   = sx16(hum_cal_ff[23:8]);
   assign h3   = {24'b0, hum_cal_ff[31:24]};
   assign h4   = {{20{hum_cal_ff[43]}}, hum_cal_ff[43:32]};
   assign h5   = {{20{hum_cal_ff[55]}}, hum_cal_ff[55:44]};
   assign h6   = {{24{hum_cal_ff[63]}}, hum_cal_ff[63:56]};

   // ---------------- valid bits ----------------
   logic        accept;
   logic        vld_pre_ff  [PRE_N];
   logic        vld_post_ff [POST_N];
   div_req_type div_req;
   div_rsp_type div_rsp;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < PRE_N; k++)  vld_pre_ff[k]  <= 1'b0;
         for (int k = 0; k < POST_N; k++) vld_post_ff[k] <= 1'b0;
      end else begin
         vld_pre_ff[0] <= accept;
         for (int k = 1; k < PRE_N; k++)  vld_pre_ff[k]  <= vld_pre_ff[k-1];
         vld_post_ff[0] <= div_rsp.vld;
         for (int k = 1; k < POST_N; k++) vld_post_ff[k] <= vld_post_ff[k-1];
      end
   end

   assign rsp_valid = vld_post_ff[POST_N-1];

   // ---------------- temperature, stages 1 to 6 ----------------
   logic signed [20:0]     d_in, d_s1_ff;
   logic signed [36:0]     m1_in, m1_s2_ff, m1_s3_ff;
   logic signed [41:0]     dd_in, dd_s2_ff;
   logic signed [57:0]     m2_in, m2_s3_ff;
   logic signed [NUM_W-1:0] num_c;
   logic signed [SQ_W-1:0] sq_in, sq_s4_ff, tf_bias, tf_full, cs_in, cs_s5_ff;
   logic signed [31:0]     tf_in, tf_s5_ff;
   logic signed [CW-1:0]   centi_full;
   logic signed [14:0]     centi_in, centi_s6_ff;

   // drop T1 offset at the door so stage 2 only multiplies
   assign d_in  = $signed({1'b0, req_raw_temperature}) - $signed({1'b0, t1_c, 4'b0000});
   assign m1_in = d_s1_ff * t2_c;
   assign dd_in = d_s1_ff * d_s1_ff;
   assign m2_in = dd_s2_ff * t3_c;
   assign num_c = (NUM_W'(m1_s3_ff) <<< 20) + NUM_W'(m2_s3_ff);
   // scale the exact quadratic onto F fraction bits, floor when dropping bits
   assign sq_in = (SQ_W'(num_c) >>> SHR) <<< SHL;
   // truncate toward zero for the fine temperature term
   assign tf_bias = {{(SQ_W-F){1'b0}}, {F{sq_s4_ff[SQ_W-1]}}};
   assign tf_full = (sq_s4_ff + tf_bias) >>> F;
   assign tf_in   = tf_full[31:0];
   assign cs_in   = (sq_s4_ff < CLO) ? CLO : ((sq_s4_ff > CHI) ? CHI : sq_s4_ff);
   // S/51.2 rounded: times 5, add half, shift by F+8
   assign centi_full = ((CW'(cs_s5_ff) <<< 2) + CW'(cs_s5_ff) + CRND) >>> (F + 8);
   assign centi_in   = centi_full[14:0];

   always_ff @(posedge clock) begin
      d_s1_ff     <= d_in;
      m1_s2_ff    <= m1_in;
      dd_s2_ff    <= dd_in;
      m1_s3_ff    <= m1_s2_ff;
      m2_s3_ff    <= m2_in;
      sq_s4_ff    <= sq_in;
      tf_s5_ff    <= tf_in;
      cs_s5_ff    <= cs_in;
      centi_s6_ff <= centi_in;
   end

   // carry raw pressure and humidity alongside
   logic [19:0] rp_ff [9];
   logic [15:0] rh_ff [6];

   always_ff @(posedge clock) begin
      rp_ff[0] <= req_raw_pressure;
      for (int k = 1; k < 9; k++) rp_ff[k] <= rp_ff[k-1];
      rh_ff[0] <= req_raw_humidity;
      for (int k = 1; k < 6; k++) rh_ff[k] <= rh_ff[k-1];
   end

   // ---------------- pressure front end, stages 6 to 11 ----------------
   logic signed [31:0] pv1_in, pv1_s6_ff, hv1_in, hv1_s6_ff;
   logic signed [31:0] pa_c, q_in, q_s7_ff, pm5_in, pm5_s7_ff, pm5_s8_ff;
   logic signed [31:0] pm2_in, pm2_s7_ff, pm2_s8_ff;
   logic signed [31:0] v2a_in, v2a_s8_ff, v3m_in, v3m_s8_ff;
   logic signed [31:0] v2c_in, v2c_s9_ff, w_in, w_s9_ff;
   logic signed [31:0] pm1_in, pm1_s10_ff, pv_c;
   logic [31:0]        pres_a_in, pres_a_s10_ff;
   logic [31:0]        dvd_in, dvd_s11_ff, dvs_s11_ff;
   logic               nz_s11_ff, hi_s11_ff;

   assign pv1_in = tdiv(tf_s5_ff, 1) - 32'sd64000;
   assign hv1_in = tf_s5_ff - 32'sd76800;
   assign pa_c   = tdiv(pv1_s6_ff, 2);
   assign q_in   = pa_c * pa_c;
   assign pm5_in = pv1_s6_ff * p5;
   assign pm2_in = p2 * pv1_s6_ff;
   assign v2a_in = tdiv(q_s7_ff, 11) * p6;
   assign v3m_in = p3 * tdiv(q_s7_ff, 13);
   assign v2c_in = tdiv(v2a_s8_ff + (pm5_s8_ff <<< 1), 2) + (p4 <<< 16);
   assign w_in   = 32'sd32768 + tdiv(tdiv(v3m_s8_ff, 3) + tdiv(pm2_s8_ff, 1), 18);
   assign pm1_in = w_s9_ff * p1;
   assign pres_a_in = (32'd1048576 - {12'b0, rp_ff[8]} - $unsigned(tdiv(v2c_s9_ff, 12)))
                      * 32'd3125;
   assign pv_c   = tdiv(pm1_s10_ff, 15);
   // keep the dividend below 2^32: double before dividing when it fits, else after
   assign dvd_in = pres_a_s10_ff[31] ? pres_a_s10_ff : {pres_a_s10_ff[30:0], 1'b0};

   always_ff @(posedge clock) begin
      pv1_s6_ff     <= pv1_in;
      hv1_s6_ff     <= hv1_in;
      q_s7_ff       <= q_in;
      pm5_s7_ff     <= pm5_in;
      pm2_s7_ff     <= pm2_in;
      v2a_s8_ff     <= v2a_in;
      v3m_s8_ff     <= v3m_in;
      pm5_s8_ff     <= pm5_s7_ff;
      pm2_s8_ff     <= pm2_s7_ff;
      v2c_s9_ff     <= v2c_in;
      w_s9_ff       <= w_in;
      pm1_s10_ff    <= pm1_in;
      pres_a_s10_ff <= pres_a_in;
      dvd_s11_ff    <= dvd_in;
      dvs_s11_ff    <= $unsigned(pv_c);
      nz_s11_ff     <= (pv_c != 32'sd0);
      hi_s11_ff     <= pres_a_s10_ff[31];
   end

   assign div_req.vld      = vld_pre_ff[PRE_N-1];
   assign div_req.dividend = dvd_s11_ff;
   assign div_req.divisor  = dvs_s11_ff;

   pthc_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // ---------------- humidity, stages 7 to 16 ----------------
   logic signed [31:0] hm5_in, hm5_s7_ff, hm6_in, hm6_s7_ff, hm3_in, hm3_s7_ff;
   logic signed [31:0] hx_in, hx_s7_ff;
   logic signed [31:0] hv5_in, hv5_ff [5];
   logic signed [31:0] hv2_in, hv2_s8_ff, hv3p_in, hv3p_s8_ff;
   logic signed [31:0] hm_in, hm_s9_ff, hv4_in, hv4_s10_ff, hm2_in, hm2_s11_ff;
   logic signed [31:0] hv2b_in, hv2b_s12_ff, hv3_in, hv3_ff [3];
   logic signed [31:0] ha_c, hsq_in, hsq_s14_ff, hm1_in, hm1_s15_ff, hf_c, hcl_c;
   logic [16:0]        hum_in, hum_s16_ff;

   assign hm5_in  = h5 * hv1_s6_ff;
   assign hm6_in  = hv1_s6_ff * h6;
   assign hm3_in  = hv1_s6_ff * h3;
   assign hx_in   = $signed({2'b00, rh_ff[5], 14'b0}) - (h4 <<< 20);
   assign hv5_in  = tdiv(hx_s7_ff - hm5_s7_ff + 32'sd16384, 15);
   assign hv2_in  = tdiv(hm6_s7_ff, 10);
   assign hv3p_in = tdiv(hm3_s7_ff, 11) + 32'sd32768;
   assign hm_in   = hv2_s8_ff * hv3p_s8_ff;
   assign hv4_in  = tdiv(hm_s9_ff, 10) + 32'sd2097152;
   assign hm2_in  = hv4_s10_ff * h2;
   assign hv2b_in = tdiv(hm2_s11_ff + 32'sd8192, 14);
   assign hv3_in  = hv5_ff[4] * hv2b_s12_ff;
   assign ha_c    = tdiv(hv3_ff[0], 15);
   assign hsq_in  = ha_c * ha_c;
   assign hm1_in  = tdiv(hsq_s14_ff, 7) * h1;
   assign hf_c    = hv3_ff[2] - tdiv(hm1_s15_ff, 4);
   // clamp to 0..100 %RH before dropping the low bits
   assign hcl_c   = hf_c[31] ? 32'sd0 : ((hf_c > 32'sd419430400) ? 32'sd419430400 : hf_c);
   assign hum_in  = hcl_c[28:12];

   always_ff @(posedge clock) begin
      hm5_s7_ff   <= hm5_in;
      hm6_s7_ff   <= hm6_in;
      hm3_s7_ff   <= hm3_in;
      hx_s7_ff    <= hx_in;
      hv5_ff[0]   <= hv5_in;
      for (int k = 1; k < 5; k++) hv5_ff[k] <= hv5_ff[k-1];
      hv2_s8_ff   <= hv2_in;
      hv3p_s8_ff  <= hv3p_in;
      hm_s9_ff    <= hm_in;
      hv4_s10_ff  <= hv4_in;
      hm2_s11_ff  <= hm2_in;
      hv2b_s12_ff <= hv2b_in;
      hv3_ff[0]   <= hv3_in;
      for (int k = 1; k < 3; k++) hv3_ff[k] <= hv3_ff[k-1];
      hsq_s14_ff  <= hsq_in;
      hm1_s15_ff  <= hm1_in;
      hum_s16_ff  <= hum_in;
   end

   // ---------------- alignment lines ----------------
   // advance temperature and humidity results to the output stage, and the
   // zero-divisor and deferred-doubling flags past the divider
   logic signed [14:0] centi_dly_ff [CENTI_DLY];
   logic [16:0]        hum_dly_ff   [HUM_DLY];
   logic [1:0]         side_dly_ff  [DIV_W];

   always_ff @(posedge clock) begin
      centi_dly_ff[0] <= centi_s6_ff;
      for (int k = 1; k < CENTI_DLY; k++) centi_dly_ff[k] <= centi_dly_ff[k-1];
      hum_dly_ff[0] <= hum_s16_ff;
      for (int k = 1; k < HUM_DLY; k++) hum_dly_ff[k] <= hum_dly_ff[k-1];
      side_dly_ff[0] <= {nz_s11_ff, hi_s11_ff};
      for (int k = 1; k < DIV_W; k++) side_dly_ff[k] <= side_dly_ff[k-1];
   end

   // ---------------- pressure back end, stages 44 to 48 ----------------
   logic [31:0]        pr_in, pr_s44_ff, pr_s45_ff, pr_s46_ff;
   logic [31:0]        sq8_in, sq8_s45_ff, pres2_in, pres2_s47_ff;
   logic signed [31:0] pm8_in, pm8_s45_ff, pm9_in, pm9_s46_ff, v2q_in, v2q_s46_ff;
   logic               nz_ff [4];
   logic [16:0]        press_in;

   // undo the halving taken when the dividend was too large to double
   assign pr_in    = side_dly_ff[DIV_W-1][0] ? {div_rsp.quotient[30:0], 1'b0}
                                             : div_rsp.quotient;
   assign sq8_in   = {3'b000, pr_s44_ff[31:3]} * {3'b000, pr_s44_ff[31:3]};
   assign pm8_in   = $signed({2'b00, pr_s44_ff[31:2]}) * p8;
   assign pm9_in   = p9 * $signed({13'b0, sq8_s45_ff[31:13]});
   assign v2q_in   = tdiv(pm8_s45_ff, 13);
   assign pres2_in = pr_s46_ff
                     + $unsigned(tdiv(tdiv(pm9_s46_ff, 12) + v2q_s46_ff + p7, 4));
   // clamp, and hold the minimum when the divisor was zero
   assign press_in = !nz_ff[3]               ? 17'd30000 :
                     (pres2_s47_ff < 32'd30000)  ? 17'd30000 :
                     (pres2_s47_ff > 32'd110000) ? 17'd110000 : pres2_s47_ff[16:0];

   always_ff @(posedge clock) begin
      pr_s44_ff    <= pr_in;
      nz_ff[0]     <= side_dly_ff[DIV_W-1][1];
      for (int k = 1; k < 4; k++) nz_ff[k] <= nz_ff[k-1];
      sq8_s45_ff   <= sq8_in;
      pm8_s45_ff   <= pm8_in;
      pr_s45_ff    <= pr_s44_ff;
      pm9_s46_ff   <= pm9_in;
      v2q_s46_ff   <= v2q_in;
      pr_s46_ff    <= pr_s45_ff;
      pres2_s47_ff <= pres2_in;
   end

   // ---------------- output register ----------------
   logic signed [14:0] out_centi_ff;
   logic [16:0]        out_press_ff, out_hum_ff;

   always_ff @(posedge clock) begin
      out_centi_ff <= centi_dly_ff[CENTI_DLY-1];
      out_press_ff <= press_in;
      out_hum_ff   <= hum_dly_ff[HUM_DLY-1];
   end

   assign rsp_temp_centi   = out_centi_ff;
   assign rsp_pressure_pa  = out_press_ff;
   assign rsp_humidity_q10 = out_hum_ff;

endmodule

>>> tb/tb_pth_sensor_compensation.sv
// Self-checking testbench for the sensor compensation pipeline.
module tb_pth_sensor_compensation
   import pthc_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PIPE_LATENCY = 48;

   typedef struct {
      logic [14:0] temp_centi;
      logic [16:0] pressure_pa;
      logic [16:0] humidity_q10;
   } reading_type;

   // Scoreboard: holds the calibration copy, computes readings, checks them in order.
   class comp_scoreboard;
      logic [63:0] cal [4];
      reading_type pending_q[$];
      int          mismatches;
      int          checked;
      int          accepted;

      function void clear_cal();
         for (int i = 0; i < 4; i++) cal[i] = '0;
      endfunction

      function reading_type compensate(logic [19:0] rt, logic [19:0] rp, logic [15:0] rh);
         reading_type r;
         int          t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
         int          h1, h2, h3, h4, h5, h6;
         longint      d, num, sq, one, cs;
         int          tf, centi, v1, v2, v3, v4, v5, q, w;
         int unsigned pres, v5u, hum_raw;
         t1 = int'({16'b0, cal[CSR_TEMP_CAL][15:0]});
         t2 = $signed(cal[CSR_TEMP_CAL][31:16]);
         t3 = $signed(cal[CSR_TEMP_CAL][47:32]);
         p9 = $signed(cal[CSR_TEMP_CAL][63:48]);
         p1 = int'({16'b0, cal[CSR_PRESS_CAL_LOW][15:0]});
         p2 = $signed(cal[CSR_PRESS_CAL_LOW][31:16]);
         p3 = $signed(cal[CSR_PRESS_CAL_LOW][47:32]);
         p4 = $signed(cal[CSR_PRESS_CAL_LOW][63:48]);
         p5 = $signed(cal[CSR_PRESS_CAL_HIGH][15:0]);
         p6 = $signed(cal[CSR_PRESS_CAL_HIGH][31:16]);
         p7 = $signed(cal[CSR_PRESS_CAL_HIGH][47:32]);
         p8 = $signed(cal[CSR_PRESS_CAL_HIGH][63:48]);
         h1 = int'({24'b0, cal[CSR_HUM_CAL][7:0]});
         h2 = $signed(cal[CSR_HUM_CAL][23:8]);
         h3 = int'({24'b0, cal[CSR_HUM_CAL][31:24]});
         h4 = $signed(cal[CSR_HUM_CAL][43:32]);
         h5 = $signed(cal[CSR_HUM_CAL][55:44]);
         h6 = $signed(cal[CSR_HUM_CAL][63:56]);

         // temperature: exact quadratic, floor to 24 fraction bits, truncate for t_fine
         d   = longint'(rt) - 16 * longint'(t1);
         num = d * longint'(t2) * 64'sd1048576 + d * d * longint'(t3);
         sq  = num >>> 10;
         one = 64'sd1 <<< 24;
         tf  = int'(sq / one);
         cs  = sq < -204800 * one ? -204800 * one : (sq > 435200 * one ? 435200 * one : sq);
         centi = int'((cs * 5 + (64'sd1 <<< 31)) >>> 32);

         // pressure: 32-bit wrap, truncating division
         v1 = tf / 2 - 64000;
         q  = (v1 / 4) * (v1 / 4);
         v2 = (q / 2048) * p6;
         v2 = v2 + v1 * p5 * 2;
         v2 = v2 / 4 + p4 * 65536;
         v3 = (p3 * (q / 8192)) / 8;
         v4 = (p2 * v1) / 2;
         v1 = (v3 + v4) / 262144;
         v1 = ((32768 + v1) * p1) / 32768;
         if (v1 != 0) begin
            v5u  = 32'd1048576 - {12'b0, rp};
            w    = v2 / 4096;
            pres = (v5u - unsigned'(w)) * 32'd3125;
            if (pres < 32'h8000_0000) pres = (pres << 1) / unsigned'(v1);
            else pres = (pres / unsigned'(v1)) * 32'd2;
            v1 = (p9 * int'(((pres / 8) * (pres / 8)) / 8192)) / 4096;
            v2 = (int'(pres / 4) * p8) / 8192;
            pres = unsigned'(int'(pres) + (v1 + v2 + p7) / 16);
            if (pres < 30000) pres = 30000;
            else if (pres > 110000) pres = 110000;
         end else begin
            pres = 30000;
         end

         // humidity
         v1 = tf - 76800;
         hum_raw = {16'b0, rh} * 32'd16384;
         v2 = int'(hum_raw);
         v3 = h4 * 1048576;
         v4 = h5 * v1;
         v5 = (v2 - v3 - v4 + 16384) / 32768;
         v2 = (v1 * h6) / 1024;
         v3 = (v1 * h3) / 2048;
         v4 = (v2 * (v3 + 32768)) / 1024 + 2097152;
         v2 = (v4 * h2 + 8192) / 16384;
         v3 = v5 * v2;
         v4 = ((v3 / 32768) * (v3 / 32768)) / 128;
         v5 = v3 - (v4 * h1) / 16;
         if (v5 < 0) v5 = 0;
         if (v5 > 419430400) v5 = 419430400;
         v5 = v5 / 4096;
         if (v5 > 102400) v5 = 102400;

         r.temp_centi   = centi[14:0];
         r.pressure_pa  = pres[16:0];
         r.humidity_q10 = v5[16:0];
         return r;
      endfunction

      function void note_request(logic [19:0] rt, logic [19:0] rp, logic [15:0] rh);
         pending_q.push_back(compensate(rt, rp, rh));
         accepted++;
      endfunction

      function void report(string what, reading_type e, reading_type a);
         mismatches++;
         if (mismatches <= 10)
            $display("%t mismatch %s: exp T=%0d P=%0d H=%0d got T=%0d P=%0d H=%0d", $realtime,
                     what, $signed(e.temp_centi), e.pressure_pa, e.humidity_q10,
                     $signed(a.temp_centi), a.pressure_pa, a.humidity_q10);
      endfunction

      function void check_result(reading_type a);
         reading_type e;
         checked++;
         if (pending_q.size() == 0) begin
            e = '{default: '0};
            report("unexpected result", e, a);
            return;
         end
         e = pending_q.pop_front();
         if (a.temp_centi !== e.temp_centi) report("temp_centi", e, a);
         if (a.pressure_pa !== e.pressure_pa) report("pressure_pa", e, a);
         if (a.humidity_q10 !== e.humidity_q10) report("humidity_q10", e, a);
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [19:0]        req_raw_temperature = '0;
   logic [19:0]        req_raw_pressure = '0;
   logic [15:0]        req_raw_humidity = '0;
   logic               rsp_valid;
   logic signed [14:0] rsp_temp_centi;
   logic [16:0]        rsp_pressure_pa;
   logic [16:0]        rsp_humidity_q10;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [4:0]         paddr = '0;
   logic [63:0]        pwdata = '0;
   logic [63:0]        prdata;
   logic               pready;

   comp_scoreboard sb = new();
   int             cal_settings;

   always #10 clock = ~clock;

   pth_sensor_compensation u_top (
      .clock, .reset, .start, .busy,
      .req_raw_temperature, .req_raw_pressure, .req_raw_humidity,
      .rsp_valid, .rsp_temp_centi, .rsp_pressure_pa, .rsp_humidity_q10,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   // Monitor: sample both channels at the edge, before any driven change lands.
   always @(posedge clock) begin
      reading_type got;
      if (!reset && start && !busy)
         sb.note_request(req_raw_temperature, req_raw_pressure, req_raw_humidity);
      if (!reset && rsp_valid) begin
         got.temp_centi   = rsp_temp_centi;
         got.pressure_pa  = rsp_pressure_pa;
         got.humidity_q10 = rsp_humidity_q10;
         sb.check_result(got);
      end
   end

   // Write one calibration register through setup and access phases, then read it back.
   task automatic write_cal(input logic [1:0] idx, input logic [63:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.cal[idx] = value;
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== value) begin
         sb.mismatches++;
         if (sb.mismatches <= 10)
            $display("%t readback of register %0d: exp %h got %h", $realtime, idx, value, prdata);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic load_cal(input logic [63:0] tc, pl, ph, hc);
      write_cal(CSR_TEMP_CAL, tc);
      write_cal(CSR_PRESS_CAL_LOW, pl);
      write_cal(CSR_PRESS_CAL_HIGH, ph);
      write_cal(CSR_HUM_CAL, hc);
      cal_settings++;
   endtask

   // Hold a request on the ports until the block takes it; start stays high for the next one.
   task automatic send_sample(input logic [19:0] rt, rp, input logic [15:0] rh);
      start               <= 1'b1;
      req_raw_temperature <= rt;
      req_raw_pressure    <= rp;
      req_raw_humidity    <= rh;
      do @(posedge clock); while (busy);
   endtask

   // Idle gap before the next request: mostly none or short, a few long.
   task automatic idle_gap(input bit burst);
      int pick;
      pick = $urandom_range(99);
      if (burst || pick < 55) return;
      start <= 1'b0;
      if (pick < 90) repeat ($urandom_range(3, 1)) @(posedge clock);
      else repeat ($urandom_range(40, 5)) @(posedge clock);
   endtask

   // Drop start and drain the pipeline before touching calibration again.
   task automatic drain();
      start <= 1'b0;
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic random_samples(input int count, input bit realistic);
      logic [19:0] rt, rp;
      logic [15:0] rh;
      bit          burst;
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) burst = $urandom_range(2) == 0;
         if (realistic && $urandom_range(3) != 0) begin
            rt = 20'(450000 + $urandom_range(150000));
            rp = 20'(250000 + $urandom_range(300000));
            rh = 16'(20000 + $urandom_range(25000));
         end else begin
            rt = 20'($urandom);
            rp = 20'($urandom);
            rh = 16'($urandom);
         end
         idle_gap(burst);
         send_sample(rt, rp, rh);
      end
   endtask

   function automatic logic [63:0] typical_cal(input logic [1:0] idx);
      case (idx)
         CSR_TEMP_CAL:       return {16'sd6000, -16'sd1000, 16'sd26435, 16'd27504};
         CSR_PRESS_CAL_LOW:  return {16'sd2855, 16'sd3024, -16'sd10685, 16'd36477};
         CSR_PRESS_CAL_HIGH: return {-16'sd14600, 16'sd15500, -16'sd7, 16'sd140};
         default: return {8'sd30, 12'sd50, 12'sd313, 8'd0, 16'sd362, 8'd75};
      endcase
   endfunction

   function automatic logic [63:0] jitter(input logic [63:0] v);
      return v ^ {4{12'b0, 4'($urandom)}};
   endfunction

   initial begin
      sb.clear_cal();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Calibration still at reset: the pressure divisor is zero.
      send_sample('0, '0, '0);
      send_sample('1, '1, '1);
      send_sample(20'd519888, 20'd415148, 16'd32768);
      drain();

      // Typical factory calibration, field extremes and clamp corners.
      load_cal(typical_cal(CSR_TEMP_CAL), typical_cal(CSR_PRESS_CAL_LOW),
               typical_cal(CSR_PRESS_CAL_HIGH), typical_cal(CSR_HUM_CAL));
      send_sample('0, '0, '0);
      send_sample('1, '1, '1);
      send_sample(20'd519888, 20'd415148, 16'd32768);
      send_sample(20'd440064, 20'd0, 16'd0);          // cold end
      send_sample(20'd1048575, 20'd1048575, 16'd65535); // hot end, low pressure
      send_sample(20'd519888, 20'd1, 16'd65535);      // high pressure, humidity clamp
      send_sample(20'd519888, 20'd600000, 16'd100);   // low humidity
      send_sample(20'h55555, 20'hAAAAA, 16'h5A5A);
      send_sample(20'hAAAAA, 20'h55555, 16'hA5A5);
      drain();

      // All-ones calibration in all four registers.
      load_cal('1, '1, '1, '1);
      send_sample('0, '0, '0);
      send_sample('1, '1, '1);
      send_sample(20'h80000, 20'h80000, 16'h8000);
      drain();

      // Most negative signed fields, largest unsigned ones.
      load_cal({4{16'h8000}} | 64'hFFFF, {4{16'h8000}} | 64'hFFFF, {4{16'h8000}},
               {8'h80, 12'h800, 12'h800, 8'hFF, 16'h8000, 8'hFF});
      send_sample('0, '0, '0);
      send_sample('1, '1, '1);
      drain();

      // Random traffic under realistic and fully random calibrations.
      load_cal(typical_cal(CSR_TEMP_CAL), typical_cal(CSR_PRESS_CAL_LOW),
               typical_cal(CSR_PRESS_CAL_HIGH), typical_cal(CSR_HUM_CAL));
      random_samples(150, 1'b1);
      drain();
      for (int k = 0; k < 3; k++) begin
         load_cal(jitter(typical_cal(CSR_TEMP_CAL)), jitter(typical_cal(CSR_PRESS_CAL_LOW)),
                  jitter(typical_cal(CSR_PRESS_CAL_HIGH)), jitter(typical_cal(CSR_HUM_CAL)));
         random_samples(70, 1'b1);
         drain();
      end
      for (int k = 0; k < 3; k++) begin
         load_cal({$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, {$urandom, $urandom});
         random_samples(60, 1'b0);
         drain();
      end

      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 10) @(posedge clock);

      $display("Checked %0d results from %0d requests across %0d calibration settings.",
               sb.checked, sb.accepted, cal_settings);
      $display("Mismatches: %0d", sb.mismatches);
      if (sb.mismatches == 0 && sb.pending_q.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #5ms;
      $display("Timeout waiting for the pipeline.");
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
